// File: src/pdc_pkg.sv
// Package for the length-prefixed packet deframer with sum checksum.
// Holds the start-byte constant, the deframer phase type and the result type.
// No dependencies; compile this file first.
package pdc_pkg;

    localparam logic [7:0] START_BYTE = 8'hFF;

    // Deframer phases, one-hot coded.
    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_SUB  = 6'b000010,
        PH_CMD  = 6'b000100,
        PH_LEN  = 6'b001000,
        PH_DATA = 6'b010000,
        PH_CSUM = 6'b100000
    } phase_t;

    // One result item as held in the output register.
    typedef struct packed {
        logic [7:0] subsystem;
        logic [7:0] command_code;
        logic [7:0] packet_length;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic       is_end;
        logic       checksum_ok;
    } result_t;

endpackage

// File: src/pdc_if.sv
// Valid/ready channel interfaces for the packet deframer.
// pdc_byte_if carries received bytes, pdc_result_if carries result items.
// No dependencies.
interface pdc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface pdc_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] subsystem;
    logic [7:0] command_code;
    logic [7:0] packet_length;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic       is_end;
    logic       checksum_ok;

    modport source (output valid, output subsystem, output command_code,
                    output packet_length, output data_byte, output data_index,
                    output is_end, output checksum_ok, input ready);
    modport sink   (input valid, input subsystem, input command_code,
                    input packet_length, input data_byte, input data_index,
                    input is_end, input checksum_ok, output ready);
endinterface

// File: src/packet_deframer_checksum.sv
// Top level of the length-prefixed packet deframer with 8-bit sum checksum.
// Depends on pdc_pkg (types, start byte) and on the interfaces in pdc_if.sv.
//
//   Port         | Direction | Payload                                | Meaning
//   -------------+-----------+----------------------------------------+--------------------
//   byte_stream  | in        | byte_in[7:0]                           | one received byte
//   result       | out       | subsystem, command_code, packet_length,| data byte or end of
//                |           | data_byte, data_index, is_end,         | packet with checksum
//                |           | checksum_ok                            | verdict
//
// The phase update and the 8-bit sum add sit between the state registers and one output
// register, so a byte can be accepted every cycle unless the output register stalls.
// Results appear in the cycle after the byte that causes them is accepted.
// While the output register holds an item that is not taken, the byte channel stalls;
// it is ready whenever the register is empty or is being emptied in the same cycle.
// Reset puts the deframer in the hunting phase with header fields and sum at zero.
module packet_deframer_checksum
    import pdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    pdc_byte_if.sink            byte_stream,
    pdc_result_if.source        result
);

    phase_t     phase_reg,       phase_next;
    logic [7:0] subsystem_reg,   subsystem_next;
    logic [7:0] command_reg,     command_next;
    logic [7:0] length_reg,      length_next;
    logic [7:0] byte_count_reg,  byte_count_next;
    logic [7:0] running_sum_reg, running_sum_next;

    logic       out_valid_reg,   out_valid_next;
    result_t    out_data_reg,    out_data_next;

    logic       accept;
    logic       emit;
    logic [7:0] b;
    logic [7:0] sum_plus;
    logic [7:0] count_plus;

    // The byte channel moves whenever the output register can take a new item.
    assign byte_stream.ready = !out_valid_reg || result.ready;
    assign accept            = byte_stream.valid && byte_stream.ready;
    assign b                 = byte_stream.byte_in;
    assign sum_plus          = running_sum_reg + b;
    assign count_plus        = byte_count_reg + 8'd1;

    // Phase decoding and state update for one accepted byte.
    always_comb
    begin
        phase_next       = phase_reg;
        subsystem_next   = subsystem_reg;
        command_next     = command_reg;
        length_next      = length_reg;
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        emit             = 1'b0;
        out_data_next    = '0;
        out_data_next.subsystem     = subsystem_reg;
        out_data_next.command_code  = command_reg;
        out_data_next.packet_length = length_reg;

        unique case (phase_reg)
            PH_SUB:
            begin
                subsystem_next   = b;
                running_sum_next = b;
                phase_next       = PH_CMD;
            end
            PH_CMD:
            begin
                command_next     = b;
                running_sum_next = sum_plus;
                phase_next       = PH_LEN;
            end
            PH_LEN:
            begin
                length_next      = b;
                running_sum_next = sum_plus;
                byte_count_next  = '0;
                // A zero-length packet goes straight to its checksum byte.
                phase_next       = (b == 8'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA:
            begin
                running_sum_next         = sum_plus;
                byte_count_next          = count_plus;
                emit                     = 1'b1;
                out_data_next.data_byte  = b;
                out_data_next.data_index = byte_count_reg;
                if (count_plus == length_reg)
                begin
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                running_sum_next          = sum_plus;
                phase_next                = PH_HUNT;
                emit                      = 1'b1;
                out_data_next.is_end      = 1'b1;
                out_data_next.checksum_ok = (sum_plus == START_BYTE);
            end
            default:
            begin
                // Hunting: every byte but the start byte is dropped.
                phase_next = PH_HUNT;
                if (b == START_BYTE)
                begin
                    running_sum_next = '0;
                    byte_count_next  = '0;
                    phase_next       = PH_SUB;
                end
            end
        endcase
    end

    // The output register fills on an accepted byte that yields a result and
    // empties when the consumer takes the item.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            subsystem_reg   <= '0;
            command_reg     <= '0;
            length_reg      <= '0;
            byte_count_reg  <= '0;
            running_sum_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg       <= phase_next;
                subsystem_reg   <= subsystem_next;
                command_reg     <= command_next;
                length_reg      <= length_next;
                byte_count_reg  <= byte_count_next;
                running_sum_reg <= running_sum_next;
            end
        end
    end

    // Payload register: no reset, loaded only with a new result.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.subsystem     = out_data_reg.subsystem;
    assign result.command_code  = out_data_reg.command_code;
    assign result.packet_length = out_data_reg.packet_length;
    assign result.data_byte     = out_data_reg.data_byte;
    assign result.data_index    = out_data_reg.data_index;
    assign result.is_end        = out_data_reg.is_end;
    assign result.checksum_ok   = out_data_reg.checksum_ok;

endmodule

// File: tb/sv/packet_deframer_checksum_tb.sv
// Self-checking testbench for the packet deframer with 8-bit sum checksum.
// Depends on pdc_pkg (start byte, phase and result types), on the channel
// interfaces in pdc_if.sv and on the packet_deframer_checksum module.
module packet_deframer_checksum_tb;
    import pdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous upper bound on the run, in nanoseconds.
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;
    // Cycles allowed for the result queue to drain at the end.
    localparam int DRAIN_LIMIT = 20000;
    // Number of framed input items the random stream aims for; together with
    // the directed tests and the dropped noise this gives about 1200 items.
    localparam int RANDOM_ITEMS = 850;

    typedef logic [7:0] byte_q_t[$];

    logic clk;
    logic rst_n;

    pdc_byte_if   bytes_ch ();
    pdc_result_if results_ch ();

    packet_deframer_checksum dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (bytes_ch),
        .result      (results_ch)
    );

    // Results the deframer must still deliver, oldest first.
    result_t pending_results[$];
    int      errors;
    // Items that the deframer actually consumes, that is every byte other
    // than a non-start byte received while hunting.
    int      framed_items;
    // When set, neither side idles.
    bit      no_idle;

    // Shadow copy of the deframer state, advanced on each accepted item.
    phase_t     m_phase;
    logic [7:0] m_subsystem;
    logic [7:0] m_command;
    logic [7:0] m_length;
    logic [7:0] m_count;
    logic [7:0] m_sum;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop in case a handshake never completes.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Advances the shadow deframer by one byte and queues the result item
    // that the byte causes, if any. A data item carries its index and the
    // latched header; the checksum byte closes the packet with the verdict.
    function automatic void deframe_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        if (!(m_phase == PH_HUNT && b != START_BYTE))
            framed_items++;
        case (m_phase)
            PH_SUB:
            begin
                m_subsystem = b;
                m_sum       = b;
                m_phase     = PH_CMD;
            end
            PH_CMD:
            begin
                m_command = b;
                m_sum     = m_sum + b;
                m_phase   = PH_LEN;
            end
            PH_LEN:
            begin
                m_length = b;
                m_sum    = m_sum + b;
                m_count  = 8'd0;
                // A zero length skips straight to the checksum byte.
                if (b == 8'd0)
                    m_phase = PH_CSUM;
                else
                    m_phase = PH_DATA;
            end
            PH_DATA:
            begin
                r.subsystem     = m_subsystem;
                r.command_code  = m_command;
                r.packet_length = m_length;
                r.data_byte     = b;
                r.data_index    = m_count;
                m_sum           = m_sum + b;
                m_count         = m_count + 8'd1;
                if (m_count == m_length)
                    m_phase = PH_CSUM;
                pending_results.push_back(r);
            end
            PH_CSUM:
            begin
                m_sum           = m_sum + b;
                m_phase         = PH_HUNT;
                r.subsystem     = m_subsystem;
                r.command_code  = m_command;
                r.packet_length = m_length;
                r.is_end        = 1'b1;
                r.checksum_ok   = (m_sum == START_BYTE);
                pending_results.push_back(r);
            end
            default:
            begin
                // Hunting: only the start byte opens a packet.
                m_phase = PH_HUNT;
                if (b == START_BYTE)
                begin
                    m_sum   = 8'd0;
                    m_count = 8'd0;
                    m_phase = PH_SUB;
                end
            end
        endcase
    endfunction

    // Offers one byte after a random idle stretch and waits until the
    // deframer takes it. Valid is left high on return, so a following item
    // with no gap goes out on the very next cycle; the caller either sends
    // again or lowers valid within the same time step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            bytes_ch.valid   <= 1'b0;
            bytes_ch.byte_in <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        bytes_ch.valid   <= 1'b1;
        bytes_ch.byte_in <= b;
        @(posedge clk);
        while (!bytes_ch.ready)
            @(posedge clk);
        deframe_byte(b);
    endtask

    // Sends a whole frame: start byte, header, payload and a checksum that
    // is either correct or deliberately wrong by one flipped bit.
    task automatic send_packet(input logic [7:0] sub, input logic [7:0] cmd,
                               input logic [7:0] len, input byte_q_t payload,
                               input bit good);
        logic [7:0] sum;
        logic [7:0] csum;
        sum = sub + cmd + len;
        foreach (payload[i])
            sum = sum + payload[i];
        csum = 8'hFF - sum;
        if (!good)
            csum = csum ^ (8'd1 << $urandom_range(0, 7));
        send_byte(START_BYTE);
        send_byte(sub);
        send_byte(cmd);
        send_byte(len);
        foreach (payload[i])
            send_byte(payload[i]);
        send_byte(csum);
    endtask

    // Random payload; some bytes are forced to the start value to show
    // that it carries no framing meaning inside a packet.
    function automatic byte_q_t random_payload(input int len);
        byte_q_t q;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                q.push_back(START_BYTE);
            else
                q.push_back(8'($urandom));
        end
        return q;
    endfunction

    // Mostly short packets, a few medium ones and rarely close to the
    // longest length that the header allows.
    function automatic logic [7:0] random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 8'($urandom_range(0, 8));
        if (r < 98)
            return 8'($urandom_range(9, 40));
        return 8'($urandom_range(250, 255));
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compares one accepted result item with the oldest expectation.
    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            $display({"%0t: unexpected result item, expected none, actual ",
                      "sub=%h cmd=%h len=%h data=%h idx=%h end=%b ok=%b"},
                     $time, results_ch.subsystem, results_ch.command_code,
                     results_ch.packet_length, results_ch.data_byte,
                     results_ch.data_index, results_ch.is_end,
                     results_ch.checksum_ok);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        check_field("subsystem", want.subsystem, results_ch.subsystem);
        check_field("command_code", want.command_code, results_ch.command_code);
        check_field("packet_length", want.packet_length, results_ch.packet_length);
        check_field("data_byte", want.data_byte, results_ch.data_byte);
        check_field("data_index", want.data_index, results_ch.data_index);
        check_field("is_end", {7'd0, want.is_end}, {7'd0, results_ch.is_end});
        check_field("checksum_ok", {7'd0, want.checksum_ok}, {7'd0, results_ch.checksum_ok});
    endtask

    // Result side: takes items whenever ready and valid meet at an edge,
    // and stalls for random stretches in between.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && results_ch.valid && results_ch.ready)
                check_result();
            if (stall_left > 0)
            begin
                results_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                results_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Non-start bytes while hunting must be dropped without a result.
    task automatic test_hunt_noise();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFE);
    endtask

    // A zero length skips the data phase. The all-zero header needs a
    // checksum byte equal to the start value, so that case comes along too.
    task automatic test_zero_length();
        byte_q_t none;
        send_packet(8'h00, 8'h00, 8'h00, none, 1'b1);
        send_packet(8'h01, 8'h02, 8'h00, none, 1'b0);
    endtask

    // Start values in the header and the payload are taken as plain bytes;
    // the deframer never resynchronizes inside a packet.
    task automatic test_start_byte_in_packet();
        byte_q_t q;
        q = {8'hFF};
        send_packet(8'hFF, 8'hFF, 8'h01, q, 1'b1);
        q = {8'hFF, 8'h00};
        send_packet(8'h00, 8'h00, 8'h02, q, 1'b0);
    endtask

    // The longest announced length, 255, drives the index up to 254.
    task automatic test_longest_packet();
        send_packet(8'($urandom), 8'($urandom), 8'hFF, random_payload(255), 1'b1);
    endtask

    // A burst of packets with neither side ever idling.
    task automatic test_back_to_back();
        logic [7:0] len;
        no_idle = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            len = 8'($urandom_range(0, 5));
            send_packet(8'($urandom), 8'($urandom), len, random_payload(int'(len)),
                        ($urandom_range(0, 1) == 1));
        end
        no_idle = 1'b0;
    endtask

    // Mostly well-formed packets with random content and a mix of good and
    // bad checksums, interleaved with bursts of arbitrary bytes that may
    // open or break frames at any point.
    task automatic test_random_stream();
        int         target;
        int         noise_len;
        logic [7:0] len;
        target = framed_items + RANDOM_ITEMS;
        while (framed_items < target)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                noise_len = $urandom_range(0, 2);
                repeat (noise_len) send_byte(8'($urandom_range(0, 254)));
                len = random_length();
                send_packet(8'($urandom), 8'($urandom), len, random_payload(int'(len)),
                            $urandom_range(0, 9) < 7);
            end
            else
            begin
                noise_len = $urandom_range(1, 6);
                repeat (noise_len) send_byte(8'($urandom));
            end
        end
    endtask

    initial
    begin : main
        int waited;
        errors       = 0;
        framed_items = 0;
        no_idle      = 1'b0;
        m_phase      = PH_HUNT;
        m_subsystem  = 8'd0;
        m_command    = 8'd0;
        m_length     = 8'd0;
        m_count      = 8'd0;
        m_sum        = 8'd0;

        rst_n = 1'b0;
        bytes_ch.valid   <= 1'b0;
        bytes_ch.byte_in <= 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hunt_noise();
        test_zero_length();
        test_start_byte_in_packet();
        test_longest_packet();
        test_back_to_back();
        test_random_stream();

        // The last item was taken at this edge; stop offering bytes.
        bytes_ch.valid <= 1'b0;

        // Let the outstanding results drain; the deframer answers in the cycle after it
        // accepts a byte, and a further wait catches any stray item.
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d result items never arrived, expected 0 left, actual %0d",
                     $time, pending_results.size(), pending_results.size());
            errors++;
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
src/pdc_pkg.sv
src/pdc_if.sv
src/packet_deframer_checksum.sv
tb/sv/packet_deframer_checksum_tb.sv
